// File: rtl/ffpa_pkg.sv
// shared types and constants of the fixed-partition first-fit allocator
// no dependencies; imported by every module of the block
package ffpa_pkg;

    // default sizing, used as the defaults of the top level parameters
    localparam int DEF_NUM_PARTITIONS = 10;
    localparam int DEF_NUM_JOBS       = 10;

    // field widths of the request and result words
    localparam int JOB_NUM_W = 4;
    localparam int REQ_KB_W  = 12;
    localparam int STATUS_W  = 3;
    localparam int PIDX_W    = 4;
    localparam int BASE_KB_W = 12;
    localparam int SIZE_KB_W = 10;

    // partition i is PART_STEP_KB * (i + 1) long
    localparam logic [SIZE_KB_W-1:0] PART_STEP_KB = SIZE_KB_W'(50);

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_JOB   = 3'd1,
        ST_ALREADY   = 3'd2,
        ST_NO_FIT    = 3'd3,
        ST_NOT_ALLOC = 3'd4
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_FINISH
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic    load;        // capture the accepted request word
        logic    scan_init;   // point the scan at partition 0
        logic    scan_step;   // advance the scan by one partition
        logic    grant;       // commit the allocation of the current partition
        logic    release_job; // commit the release of the job's partition
        logic    set_status;  // latch the result status
        t_status status;
        logic    emit;        // move the result into the output register
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic job_bad;      // job number out of range
        logic job_active;   // job already holds a partition
        logic mode_release; // request is a release
        logic fit;          // current partition is free and large enough
        logic scan_last;    // current partition is the last one
        logic out_free;     // output register can take a new word
    } t_sts;

endpackage

// File: rtl/ffpa_ctrl.sv
// controller state machine of the allocator: sequences check, scan and result
// depends on ffpa_pkg
module ffpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ffpa_pkg::t_sts i_sts,
    output ffpa_pkg::t_cmd o_cmd
);
    import ffpa_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.status = ST_OK;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.set_status = 1'b1;
                n_state          = S_FINISH;
                if (i_sts.job_bad) begin
                    o_cmd.status = ST_BAD_JOB;
                end else if (!i_sts.mode_release) begin
                    if (i_sts.job_active) begin
                        o_cmd.status = ST_ALREADY;
                    end else begin
                        o_cmd.set_status = 1'b0;
                        o_cmd.scan_init  = 1'b1;
                        n_state          = S_SCAN;
                    end
                end else if (!i_sts.job_active) begin
                    o_cmd.status = ST_NOT_ALLOC;
                end else begin
                    o_cmd.release_job = 1'b1;
                    o_cmd.status      = ST_OK;
                end
            end
            S_SCAN: begin
                if (i_sts.fit) begin
                    o_cmd.grant      = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_OK;
                    n_state          = S_FINISH;
                end else if (i_sts.scan_last) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NO_FIT;
                    n_state          = S_FINISH;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/ffpa_datapath.sv
// datapath of the allocator: request word, busy and ownership tables,
// running partition base and size, and the result output register; uses ffpa_pkg
module ffpa_datapath #(
    parameter int NUM_PARTITIONS = ffpa_pkg::DEF_NUM_PARTITIONS,
    parameter int NUM_JOBS       = ffpa_pkg::DEF_NUM_JOBS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_mode,
    input  logic [ffpa_pkg::JOB_NUM_W-1:0]  i_job_number,
    input  logic [ffpa_pkg::REQ_KB_W-1:0]   i_request_kb,
    input  ffpa_pkg::t_cmd                  i_cmd,
    output ffpa_pkg::t_sts                  o_sts,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ffpa_pkg::STATUS_W-1:0]   o_status,
    output logic [ffpa_pkg::PIDX_W-1:0]     o_partition_index,
    output logic [ffpa_pkg::BASE_KB_W-1:0]  o_base_kb,
    output logic [ffpa_pkg::SIZE_KB_W-1:0]  o_granted_kb
);
    import ffpa_pkg::*;

    localparam int PART_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
    localparam int JOB_W  = (NUM_JOBS > 1) ? $clog2(NUM_JOBS) : 1;

    // request word
    logic                  r_mode;
    logic [JOB_NUM_W-1:0]  r_job;
    logic [REQ_KB_W-1:0]   r_req;

    // scan position with running size and base of the current partition
    logic [PIDX_W-1:0]     r_idx;
    logic [SIZE_KB_W-1:0]  r_size;
    logic [BASE_KB_W-1:0]  r_base;
    t_status               r_status;

    // allocation tables
    logic [NUM_PARTITIONS-1:0] r_busy;
    logic [NUM_JOBS-1:0]       r_active;
    logic [PIDX_W-1:0]         r_job_part [NUM_JOBS];

    // output register
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [PIDX_W-1:0]     r_out_pidx;
    logic [BASE_KB_W-1:0]  r_out_base;
    logic [SIZE_KB_W-1:0]  r_out_size;

    logic                  job_bad;
    logic [JOB_W-1:0]      jidx;
    logic [PART_W-1:0]     pidx;
    logic [PIDX_W-1:0]     held_part;
    logic                  held_in_range;
    logic                  res_ok;
    logic                  res_alloc_ok;

    // table lookups for the current request and scan position
    assign job_bad       = (r_job >= JOB_NUM_W'(NUM_JOBS));
    assign jidx          = r_job[JOB_W-1:0];
    assign pidx          = r_idx[PART_W-1:0];
    assign held_part     = r_job_part[jidx];
    assign held_in_range = (held_part < PIDX_W'(NUM_PARTITIONS));

    assign o_sts.job_bad      = job_bad;
    assign o_sts.job_active   = !job_bad && r_active[jidx];
    assign o_sts.mode_release = r_mode;
    assign o_sts.fit          = !r_busy[pidx] && (REQ_KB_W'(r_size) >= r_req);
    assign o_sts.scan_last    = (r_idx == PIDX_W'(NUM_PARTITIONS - 1));
    assign o_sts.out_free     = !r_out_valid || i_out_ready;

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_job  <= i_job_number;
            r_req  <= i_request_kb;
        end
    end

    // scan counter, running partition size and base, result status
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_idx  <= '0;
            r_size <= PART_STEP_KB;
            r_base <= '0;
        end else if (i_cmd.scan_step) begin
            r_idx  <= r_idx + PIDX_W'(1);
            r_size <= r_size + PART_STEP_KB;
            r_base <= r_base + BASE_KB_W'(r_size);
        end else if (i_cmd.release_job) begin
            r_idx  <= held_part;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
    end

    // busy and active bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= '0;
            r_active <= '0;
        end else if (i_cmd.grant) begin
            r_busy[pidx]   <= 1'b1;
            r_active[jidx] <= 1'b1;
        end else if (i_cmd.release_job) begin
            if (held_in_range) begin
                r_busy[held_part[PART_W-1:0]] <= 1'b0;
            end
            r_active[jidx] <= 1'b0;
        end
    end

    // partition held by each job, written on grant
    always_ff @(posedge i_clk) begin
        if (i_cmd.grant) begin
            r_job_part[jidx] <= r_idx;
        end
    end

    // result fields are zero where the request failed; a release reports only the partition index
    assign res_ok       = (r_status == ST_OK);
    assign res_alloc_ok = res_ok && !r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= r_status;
            r_out_pidx   <= res_ok ? r_idx : '0;
            r_out_base   <= res_alloc_ok ? r_base : '0;
            r_out_size   <= res_alloc_ok ? r_size : '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_partition_index = r_out_pidx;
    assign o_base_kb         = r_out_base;
    assign o_granted_kb      = r_out_size;

endmodule

// File: rtl/fixed_partition_first_fit_allocator.sv
// Fixed-partition first-fit allocator. Each request word (allocate or release) gives
// exactly one result word. A release or a rejected request passes from acceptance
// through the check state and the finish state to the result register; an allocate
// also passes through the scan state, examining 1 to NUM_PARTITIONS partitions; the scan visits one
// partition per cycle, tracking its size and start address with running adders. The finish state
// waits until the output register is free. One request is worked on at a time, and the next one is
// accepted the cycle after the result register loads; a finished result waits in the output register
// while the next request is accepted and checked. Busy and active bits clear at reset.
// depends on ffpa_pkg, ffpa_ctrl, ffpa_datapath
module fixed_partition_first_fit_allocator #(
    parameter int NUM_PARTITIONS = ffpa_pkg::DEF_NUM_PARTITIONS,
    parameter int NUM_JOBS       = ffpa_pkg::DEF_NUM_JOBS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_mode,
    input  logic [ffpa_pkg::JOB_NUM_W-1:0]  i_job_number,
    input  logic [ffpa_pkg::REQ_KB_W-1:0]   i_request_kb,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ffpa_pkg::STATUS_W-1:0]   o_status,
    output logic [ffpa_pkg::PIDX_W-1:0]     o_partition_index,
    output logic [ffpa_pkg::BASE_KB_W-1:0]  o_base_kb,
    output logic [ffpa_pkg::SIZE_KB_W-1:0]  o_granted_kb
);
    import ffpa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // controller
    ffpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    ffpa_datapath #(
        .NUM_PARTITIONS (NUM_PARTITIONS),
        .NUM_JOBS       (NUM_JOBS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_mode            (i_mode),
        .i_job_number      (i_job_number),
        .i_request_kb      (i_request_kb),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_partition_index (o_partition_index),
        .o_base_kb         (o_base_kb),
        .o_granted_kb      (o_granted_kb)
    );

endmodule

// File: rtl/ffpa_checker.sv
// port-level checks of the allocator, attached to the top level by bind
// depends on ffpa_pkg and fixed_partition_first_fit_allocator
module ffpa_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [ffpa_pkg::STATUS_W-1:0]   o_status,
    input logic [ffpa_pkg::PIDX_W-1:0]     o_partition_index,
    input logic [ffpa_pkg::BASE_KB_W-1:0]  o_base_kb,
    input logic [ffpa_pkg::SIZE_KB_W-1:0]  o_granted_kb
);
    import ffpa_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_partition_index) && $stable(o_base_kb) && $stable(o_granted_kb))
        else $error("result word changed while stalled");

    // one request at a time: no acceptance right after an acceptance
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while one is in flight");

    // status is a defined code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_BAD_JOB
            || o_status == ST_ALREADY || o_status == ST_NO_FIT || o_status == ST_NOT_ALLOC))
        else $error("undefined status code");

    // a failed request carries zero fields
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_partition_index == '0
            && o_base_kb == '0 && o_granted_kb == '0)
        else $error("nonzero fields on a failed request");

    // a granted size matches the partition number
    a_grant_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_OK && o_granted_kb != '0
            |-> 32'(o_granted_kb) == 32'(o_partition_index + 1) * 32'd50)
        else $error("granted size does not match partition");

endmodule

bind fixed_partition_first_fit_allocator ffpa_checker u_ffpa_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_status          (o_status),
    .o_partition_index (o_partition_index),
    .o_base_kb         (o_base_kb),
    .o_granted_kb      (o_granted_kb)
);

// File: tb/fixed_partition_first_fit_allocator_chk.sv
// checker for the fixed-partition first-fit allocator: watches both channels,
// predicts each result word and compares it field by field
// depends on ffpa_pkg
`timescale 1ns / 1ps

module fixed_partition_first_fit_allocator_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic                            i_mode,
    input  logic [ffpa_pkg::JOB_NUM_W-1:0]  i_job_number,
    input  logic [ffpa_pkg::REQ_KB_W-1:0]   i_request_kb,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [ffpa_pkg::STATUS_W-1:0]   i_status,
    input  logic [ffpa_pkg::PIDX_W-1:0]     i_partition_index,
    input  logic [ffpa_pkg::BASE_KB_W-1:0]  i_base_kb,
    input  logic [ffpa_pkg::SIZE_KB_W-1:0]  i_granted_kb,
    output int                              o_errors,
    output int                              o_outstanding
);
    import ffpa_pkg::*;

    localparam int NUM_PARTS = DEF_NUM_PARTITIONS;
    localparam int NUM_JOBS  = DEF_NUM_JOBS;

    typedef struct packed {
        t_status              status;
        logic [PIDX_W-1:0]    part;
        logic [BASE_KB_W-1:0] base_kb;
        logic [SIZE_KB_W-1:0] size_kb;
    } t_grant_word;

    // shadow of the allocation tables
    logic              part_busy [NUM_PARTS];
    logic              job_holds [NUM_JOBS];
    logic [PIDX_W-1:0] job_part  [NUM_JOBS];

    t_grant_word awaited_grants[$];
    int          errors = 0;

    // partition p is 50*(p+1) KB long
    function automatic int part_size_kb(input int p);
        return int'(PART_STEP_KB) * (p + 1);
    endfunction

    // partition p starts at 25*p*(p+1) KB
    function automatic int part_base_kb(input int p);
        return (int'(PART_STEP_KB) * p * (p + 1)) / 2;
    endfunction

    // first-fit decision for one request word, updating the shadow tables
    function automatic t_grant_word serve_request(input logic is_release,
                                                  input logic [JOB_NUM_W-1:0] job,
                                                  input logic [REQ_KB_W-1:0] kb);
        t_grant_word r;
        int          hit;
        r        = '0;
        r.status = ST_OK;
        hit      = -1;
        if (int'(job) >= NUM_JOBS) begin
            r.status = ST_BAD_JOB;
        end else if (!is_release) begin
            if (job_holds[job]) begin
                r.status = ST_ALREADY;
            end else begin
                // lowest-numbered free partition that is big enough
                for (int p = 0; p < NUM_PARTS; p++) begin
                    if (hit < 0 && !part_busy[p] && part_size_kb(p) >= int'(kb))
                        hit = p;
                end
                if (hit < 0) begin
                    r.status = ST_NO_FIT;
                end else begin
                    part_busy[hit] = 1'b1;
                    job_holds[job] = 1'b1;
                    job_part[job]  = PIDX_W'(hit);
                    r.part         = PIDX_W'(hit);
                    r.base_kb      = BASE_KB_W'(part_base_kb(hit));
                    r.size_kb      = SIZE_KB_W'(part_size_kb(hit));
                end
            end
        end else if (!job_holds[job]) begin
            r.status = ST_NOT_ALLOC;
        end else begin
            // release reports the freed partition only
            part_busy[job_part[job]] = 1'b0;
            job_holds[job]           = 1'b0;
            r.part                   = job_part[job];
        end
        return r;
    endfunction

    // sample both channels at the rising edge
    always @(posedge i_clk) begin : watch
        t_grant_word want;
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PARTS; p++)
                part_busy[p] = 1'b0;
            for (int j = 0; j < NUM_JOBS; j++) begin
                job_holds[j] = 1'b0;
                job_part[j]  = '0;
            end
            awaited_grants.delete();
        end else begin
            // accepted request word
            if (i_in_valid && i_in_ready)
                awaited_grants.push_back(serve_request(i_mode, i_job_number, i_request_kb));

            // accepted result word
            if (i_out_valid && i_out_ready) begin
                if (awaited_grants.size() == 0) begin
                    $error("result word with nothing pending: status %0d partition %0d",
                           i_status, i_partition_index);
                    errors++;
                end else begin
                    want = awaited_grants.pop_front();
                    if (i_status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, i_status);
                        errors++;
                    end
                    if (i_partition_index !== want.part) begin
                        $error("partition_index mismatch: expected %0d, got %0d",
                               want.part, i_partition_index);
                        errors++;
                    end
                    if (i_base_kb !== want.base_kb) begin
                        $error("base_kb mismatch: expected %0d, got %0d",
                               want.base_kb, i_base_kb);
                        errors++;
                    end
                    if (i_granted_kb !== want.size_kb) begin
                        $error("granted_kb mismatch: expected %0d, got %0d",
                               want.size_kb, i_granted_kb);
                        errors++;
                    end
                end
            end
        end
        o_errors      = errors;
        o_outstanding = awaited_grants.size();
    end

endmodule

// File: tb/fixed_partition_first_fit_allocator_tb.sv
// top of the allocator testbench: clock, reset, request stimulus, result-side stalls
// and the verdict; depends on ffpa_pkg, the allocator and its checker
`timescale 1ns / 1ps

module fixed_partition_first_fit_allocator_tb;
    import ffpa_pkg::*;

    localparam int   NUM_JOBS       = DEF_NUM_JOBS;
    localparam int   RANDOM_WORDS   = 1830;
    localparam int   WATCHDOG_LIMIT = 4000;
    localparam int   HOLD_OFF_AT    = 3000;
    localparam int   HOLD_OFF_LEN   = 400;
    localparam logic MODE_ALLOC     = 1'b0;
    localparam logic MODE_RELEASE   = 1'b1;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic                 in_mode   = MODE_ALLOC;
    logic [JOB_NUM_W-1:0] in_job    = '0;
    logic [REQ_KB_W-1:0]  in_kb     = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [STATUS_W-1:0]  out_status;
    logic [PIDX_W-1:0]    out_part;
    logic [BASE_KB_W-1:0] out_base_kb;
    logic [SIZE_KB_W-1:0] out_size_kb;

    int errors;
    int outstanding;
    int burst_left = 1;
    int idle_cycles = 0;

    fixed_partition_first_fit_allocator dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_mode            (in_mode),
        .i_job_number      (in_job),
        .i_request_kb      (in_kb),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_status          (out_status),
        .o_partition_index (out_part),
        .o_base_kb         (out_base_kb),
        .o_granted_kb      (out_size_kb)
    );

    fixed_partition_first_fit_allocator_chk chk (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_mode            (in_mode),
        .i_job_number      (in_job),
        .i_request_kb      (in_kb),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_status          (out_status),
        .i_partition_index (out_part),
        .i_base_kb         (out_base_kb),
        .i_granted_kb      (out_size_kb),
        .o_errors          (errors),
        .o_outstanding     (outstanding)
    );

    // 8 ns clock
    initial begin
        forever #4 clk = ~clk;
    end

    // offer one request word and hold it until accepted, then pace the bursts
    task automatic send_word(input logic mode, input logic [JOB_NUM_W-1:0] job,
                             input logic [REQ_KB_W-1:0] kb);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        in_mode  <= mode;
        in_job   <= job;
        in_kb    <= kb;
        do @(posedge clk); while (!in_ready);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            // mostly short bursts, now and then a long unbroken stretch
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // request sizes: some at or just above a partition size, the rest random
    function automatic logic [REQ_KB_W-1:0] pick_kb();
        int k;
        k = $urandom_range(1, 10);
        case ($urandom_range(0, 19))
            14, 15:      return REQ_KB_W'(int'(PART_STEP_KB) * k);
            16:          return REQ_KB_W'(int'(PART_STEP_KB) * k + 1);
            17, 18, 19:  return REQ_KB_W'($urandom_range(0, 4095));
            default:     return REQ_KB_W'($urandom_range(0, 500));
        endcase
    endfunction

    // result side: stall patterns in spans, plus one long hold-off
    initial begin : result_side
        int rx_cycles;
        int span;
        int style;
        bit held_off;
        rx_cycles = 0;
        held_off  = 1'b0;
        forever begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(8, 120);
            repeat (span) begin
                @(negedge clk);
                rx_cycles++;
                case (style)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (rx_cycles % 3 == 0);
                endcase
            end
            if (!held_off && rx_cycles >= HOLD_OFF_AT) begin
                // let the block fill up and push back on requests
                held_off = 1'b1;
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(negedge clk);
                rx_cycles += HOLD_OFF_LEN + 1;
            end
        end
    end

    // give up when no word moves on either channel for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        int   alloc_pct;
        logic mode;
        logic [JOB_NUM_W-1:0] job;
        alloc_pct = 50;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero size takes partition 0, then the same job again
        send_word(MODE_ALLOC, 4'd0, 12'd0);
        send_word(MODE_ALLOC, 4'd0, 12'd0);
        // out-of-range job in both modes
        send_word(MODE_ALLOC, 4'd15, 12'd4095);
        send_word(MODE_RELEASE, 4'd15, 12'd0);
        // release of a job holding nothing
        send_word(MODE_RELEASE, 4'd1, 12'd0);
        // exact fit into the largest partition, then two that fit nowhere, then a small one
        send_word(MODE_ALLOC, 4'd1, 12'd500);
        send_word(MODE_ALLOC, 4'd2, 12'd501);
        send_word(MODE_ALLOC, 4'd3, 12'd4095);
        send_word(MODE_ALLOC, 4'd9, 12'd50);
        // free partition 0 and hand it out again
        send_word(MODE_RELEASE, 4'd0, 12'd4095);
        send_word(MODE_ALLOC, 4'd4, 12'd1);
        send_word(MODE_RELEASE, 4'd1, 12'd0);
        // fill every partition
        for (int j = 0; j < NUM_JOBS; j++) begin
            if (j != 4 && j != 9)
                send_word(MODE_ALLOC, JOB_NUM_W'(j), 12'd0);
        end
        send_word(MODE_RELEASE, 4'd8, 12'd0);
        send_word(MODE_RELEASE, 4'd4, 12'd0);

        // random phases, each leaning toward allocate or release
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 64 == 0) begin
                case ($urandom_range(0, 3))
                    0:       alloc_pct = 15;
                    1:       alloc_pct = 50;
                    2:       alloc_pct = 85;
                    default: alloc_pct = 100;
                endcase
            end
            mode = ($urandom_range(1, 100) <= alloc_pct) ? MODE_ALLOC : MODE_RELEASE;
            job  = ($urandom_range(0, 9) == 0) ? JOB_NUM_W'($urandom_range(NUM_JOBS, 15))
                                               : JOB_NUM_W'($urandom_range(0, NUM_JOBS - 1));
            send_word(mode, job, pick_kb());
        end

        // drain, then a short quiet tail for stray result words
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
